[hdl/sspd_pkg.sv]
// ----------------------------------------------------------------------------
// sspd_pkg
// Shared types, constants and field decode functions for the status packet
// decoder.
// ----------------------------------------------------------------------------
package sspd_pkg;

  localparam int PACKET_BYTES = 13;
  localparam int STORE_BYTES  = 12;
  localparam int IDX_W        = $clog2(PACKET_BYTES);
  localparam int SUM_W        = 12;
  localparam int LEVEL_W      = 13;
  localparam int PROD_W       = 22;

  localparam logic [SUM_W-1:0]  SUM_GOOD  = 12'h0FF;
  localparam logic [15:0]       THR_OK     = 16'd1023;
  localparam logic [15:0]       THR_CANCEL = 16'd720;
  localparam logic [15:0]       THR_RIGHT  = 16'd270;
  localparam logic [15:0]       THR_LEFT   = 16'd60;
  localparam logic [PROD_W-1:0] LEVEL_MUL  = 22'd3545;

  typedef enum logic [2:0] {
    BTN_NONE   = 3'd0,
    BTN_LEFT   = 3'd1,
    BTN_RIGHT  = 3'd2,
    BTN_CANCEL = 3'd3,
    BTN_OK     = 3'd4
  } button_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        sensor_a;
    logic [15:0]        sensor_b;
    logic [15:0]        sensor_c;
    logic [15:0]        sensor_d;
    logic [2:0]         button_code;
    logic [1:0]         version_major;
    logic [2:0]         version_minor;
    logic               battery_is_pack;
    logic [LEVEL_W-1:0] battery_level;
  } held_t;

  typedef struct packed {
    logic               packet_ok;
    logic [15:0]        sensor_a;
    logic [15:0]        sensor_b;
    logic [15:0]        sensor_c;
    logic [15:0]        sensor_d;
    logic [2:0]         button_code;
    logic [1:0]         version_major;
    logic [2:0]         version_minor;
    logic               battery_is_pack;
    logic [LEVEL_W-1:0] battery_level;
  } out_word_t;

  function automatic logic [2:0] button_from(logic [15:0] w);
    button_t b;
    if (w > THR_OK) begin
      b = BTN_OK;
    end else if (w > THR_CANCEL) begin
      b = BTN_CANCEL;
    end else if (w > THR_RIGHT) begin
      b = BTN_RIGHT;
    end else if (w > THR_LEFT) begin
      b = BTN_LEFT;
    end else begin
      b = BTN_NONE;
    end
    return 3'(b);
  endfunction

  function automatic logic [LEVEL_W-1:0] level_from(logic [9:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * LEVEL_MUL;
    return p[PROD_W-1:9];
  endfunction

endpackage

[hdl/sspd_in_reg.sv]
// ----------------------------------------------------------------------------
// sspd_in_reg
// Input register: holds one received word until the decoder core takes it.
// ----------------------------------------------------------------------------
module sspd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sspd_pkg::in_word_t in_word,
  input  logic              take,
  output logic              s1_valid,
  output sspd_pkg::in_word_t s1_word
);
  import sspd_pkg::*;

  logic     valid_r, valid_nxt;
  in_word_t word_r;
  logic     load;

  assign load      = !valid_r || take;
  assign in_stall  = !load;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

[hdl/sspd_core.sv]
// ----------------------------------------------------------------------------
// sspd_core
// Packet assembly, byte sum check, held value update and result register.
// ----------------------------------------------------------------------------
module sspd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  sspd_pkg::in_word_t s1_word,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output sspd_pkg::out_word_t out_word
);
  import sspd_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt, idx_eff;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_eff, sum_new;
  logic [7:0]       store_r [STORE_BYTES];
  logic [7:0]       pkt     [STORE_BYTES];
  held_t            held_r, held_nxt;
  logic             ok_r, out_valid_r, out_valid_nxt;
  logic             last, ok, done;
  logic [15:0]      btn_w, stat_w;

  assign idx_eff = s1_word.packet_start ? '0 : idx_r;
  assign sum_eff = s1_word.packet_start ? '0 : sum_r;
  assign sum_new = sum_eff + SUM_W'(s1_word.rx_byte);
  assign last    = (idx_eff == IDX_W'(PACKET_BYTES - 1));
  assign ok      = (sum_new == SUM_GOOD);
  assign take    = s1_valid && (!last || !out_valid_r || !out_stall);
  assign done    = take && last;

  // forward the current byte into its slot
  always_comb begin
    for (int k = 0; k < STORE_BYTES; k++) begin
      pkt[k] = (idx_eff == IDX_W'(k)) ? s1_word.rx_byte : store_r[k];
    end
  end

  assign btn_w  = {pkt[9], pkt[8]};
  assign stat_w = {pkt[11], pkt[10]};

  always_comb begin
    idx_nxt = last ? '0 : idx_eff + IDX_W'(1);
    sum_nxt = last ? '0 : sum_new;
    held_nxt                 = held_r;
    held_nxt.sensor_a        = {pkt[1], pkt[0]};
    held_nxt.sensor_b        = {pkt[3], pkt[2]};
    held_nxt.sensor_c        = {pkt[5], pkt[4]};
    held_nxt.sensor_d        = {pkt[7], pkt[6]};
    held_nxt.button_code     = button_from(btn_w);
    held_nxt.version_major   = stat_w[14:13];
    held_nxt.version_minor   = stat_w[12:10];
    held_nxt.battery_is_pack = !stat_w[15];
    held_nxt.battery_level   = level_from(stat_w[9:0]);
    out_valid_nxt = done ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sum_r       <= '0;
      held_r      <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        idx_r <= idx_nxt;
        sum_r <= sum_nxt;
      end
      if (done) begin
        ok_r <= ok;
      end
      if (done && ok) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STORE_BYTES; k++) begin
      if (take && idx_eff == IDX_W'(k)) begin
        store_r[k] <= s1_word.rx_byte;
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_word.packet_ok       = ok_r;
  assign out_word.sensor_a        = held_r.sensor_a;
  assign out_word.sensor_b        = held_r.sensor_b;
  assign out_word.sensor_c        = held_r.sensor_c;
  assign out_word.sensor_d        = held_r.sensor_d;
  assign out_word.button_code     = held_r.button_code;
  assign out_word.version_major   = held_r.version_major;
  assign out_word.version_minor   = held_r.version_minor;
  assign out_word.battery_is_pack = held_r.battery_is_pack;
  assign out_word.battery_level   = held_r.battery_level;

endmodule

[hdl/sensor_status_packet_decoder_top.sv]
// ----------------------------------------------------------------------------
// sensor_status_packet_decoder_top
// Status packet decoder: takes one packet byte per word and reports the
// held sensor, button and battery values once per packet.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle unless the input stalls. A byte passes
// through the input register and is folded into the running sum and the
// packet store when the core takes it; on the last byte of a packet the
// core then registers the result word at the output. The output register
// holds one result, so input only stalls when the last byte of a packet
// arrives while the previous result is still stalled at the output.
module sensor_status_packet_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sspd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sspd_pkg::out_word_t out_word
);
  import sspd_pkg::*;

  logic     s1_valid;
  in_word_t s1_word;
  logic     take;

  sspd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  sspd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_word   (s1_word),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[bench/tb_sensor_status_packet_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_sensor_status_packet_decoder_top
// Self-checking bench for the status packet decoder. Byte words are fed
// through the input channel in bursts with random gaps, while the result
// channel stalls on its own pattern and once holds off for a long stretch.
// A local decoder model predicts every status report, and each accepted
// report is compared field by field with the oldest prediction. Directed
// packets cover a bad sum, a restart in mid-packet and a packet following
// on without a start mark. Random traffic then mixes good packets, spoilt
// sums, cut-off packets and stray bytes.
// ----------------------------------------------------------------------------
module tb_sensor_status_packet_decoder_top;

  import sspd_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 1100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  sensor_status_packet_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  // decoder model state
  logic [4:0]  pkt_index = '0;
  logic [11:0] pkt_sum = '0;
  logic [7:0]  pkt_store [STORE_BYTES];
  held_t       held = '0;
  out_word_t   report_q [$];

  logic [7:0]  pkt [PACKET_BYTES];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  int          hold_requests = 0;
  int          hold_served = 0;

  task automatic absorb_byte(input in_word_t w);
    logic [15:0] btn_w;
    logic [15:0] stat_w;
    logic [21:0] prod;
    out_word_t   rep;
    if (w.packet_start) begin
      pkt_index = '0;
      pkt_sum   = '0;
    end
    if (pkt_index < STORE_BYTES) pkt_store[pkt_index] = w.rx_byte;
    pkt_sum   = pkt_sum + 12'(w.rx_byte);
    pkt_index = pkt_index + 5'd1;
    if (pkt_index == PACKET_BYTES) begin
      rep.packet_ok = (pkt_sum == 12'hFF);
      pkt_index = '0;
      pkt_sum   = '0;
      if (rep.packet_ok) begin
        held.sensor_a = {pkt_store[1], pkt_store[0]};
        held.sensor_b = {pkt_store[3], pkt_store[2]};
        held.sensor_c = {pkt_store[5], pkt_store[4]};
        held.sensor_d = {pkt_store[7], pkt_store[6]};
        btn_w = {pkt_store[9], pkt_store[8]};
        if (btn_w > 16'd1023)     held.button_code = BTN_OK;
        else if (btn_w > 16'd720) held.button_code = BTN_CANCEL;
        else if (btn_w > 16'd270) held.button_code = BTN_RIGHT;
        else if (btn_w > 16'd60)  held.button_code = BTN_LEFT;
        else                      held.button_code = BTN_NONE;
        stat_w = {pkt_store[11], pkt_store[10]};
        prod = 22'(stat_w[9:0]) * 22'd3545;
        held.battery_level   = prod[21:9];
        held.battery_is_pack = ~stat_w[15];
        held.version_minor   = stat_w[12:10];
        held.version_major   = stat_w[14:13];
      end
      rep.sensor_a        = held.sensor_a;
      rep.sensor_b        = held.sensor_b;
      rep.sensor_c        = held.sensor_c;
      rep.sensor_d        = held.sensor_d;
      rep.button_code     = held.button_code;
      rep.version_major   = held.version_major;
      rep.version_minor   = held.version_minor;
      rep.battery_is_pack = held.battery_is_pack;
      rep.battery_level   = held.battery_level;
      report_q.push_back(rep);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    int       gap;
    in_word_t w;
    w.rx_byte      = b;
    w.packet_start = st;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(w);
    bytes_sent++;
  endtask

  task automatic send_packet(input int count, input logic st);
    for (int i = 0; i < count; i++) send_byte(pkt[i], (i == 0) ? st : 1'b0);
  endtask

  function automatic logic [15:0] button_edge(input int k);
    case (k)
      0: return 16'd60;
      1: return 16'd61;
      2: return 16'd270;
      3: return 16'd271;
      4: return 16'd720;
      5: return 16'd721;
      6: return 16'd1023;
      default: return 16'd1024;
    endcase
  endfunction

  // good packet: bytes sum to exactly 0xFF, remainder lands in the last byte
  task automatic fill_good();
    int          rem;
    int          pos;
    int          room;
    logic [15:0] w;
    logic [7:0]  b;
    for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'h00;
    rem = 255;
    if ($urandom_range(0, 2) == 0) begin
      w = button_edge($urandom_range(0, 7));
      if (int'(w[7:0]) + int'(w[15:8]) <= rem) begin
        pkt[8] = w[7:0];
        pkt[9] = w[15:8];
        rem -= int'(w[7:0]) + int'(w[15:8]);
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (int'(b) <= rem) begin
        pkt[11] = b;
        rem -= int'(b);
      end
    end
    repeat ($urandom_range(1, 10)) begin
      pos  = $urandom_range(0, STORE_BYTES - 1);
      room = 255 - int'(pkt[pos]);
      if (room > rem) room = rem;
      b = 8'($urandom_range(0, room));
      pkt[pos] = pkt[pos] + b;
      rem -= int'(b);
    end
    pkt[PACKET_BYTES-1] = 8'(rem);
  endtask

  task automatic spoil_packet();
    int pos;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'($urandom_range(0, 255));
    end else begin
      pos = $urandom_range(0, PACKET_BYTES - 1);
      if (pkt[pos] == 8'hFF) pkt[pos] = pkt[pos] - 8'($urandom_range(1, 255));
      else pkt[pos] = pkt[pos] + 8'($urandom_range(1, 255 - int'(pkt[pos])));
    end
  endtask

  function automatic logic start_mark();
    return (pkt_index == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
  endfunction

  // receiver stall pattern and long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(64, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("status report with none predicted");
        mismatches++;
      end else begin
        e = report_q.pop_front();
        check_field("packet_ok", e.packet_ok, out_word.packet_ok);
        check_field("sensor_a", e.sensor_a, out_word.sensor_a);
        check_field("sensor_b", e.sensor_b, out_word.sensor_b);
        check_field("sensor_c", e.sensor_c, out_word.sensor_c);
        check_field("sensor_d", e.sensor_d, out_word.sensor_d);
        check_field("button_code", e.button_code, out_word.button_code);
        check_field("version_major", e.version_major, out_word.version_major);
        check_field("version_minor", e.version_minor, out_word.version_minor);
        check_field("battery_is_pack", e.battery_is_pack, out_word.battery_is_pack);
        check_field("battery_level", e.battery_level, out_word.battery_level);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && report_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_sensor_status_packet_decoder_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_bad_sum();
    for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'hFF;
    send_packet(PACKET_BYTES, 1'b1);
  endtask

  task automatic test_restart_mid_packet();
    for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'h00;
    send_packet(4, 1'b1);
    pkt[3]  = 8'h10;
    pkt[9]  = 8'h04;
    pkt[11] = 8'h80;
    pkt[PACKET_BYTES-1] = 8'(255 - 8'h94);
    send_packet(PACKET_BYTES, 1'b1);
  endtask

  task automatic test_packet_without_start();
    for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'h00;
    pkt[0]  = 8'h01;
    pkt[8]  = 8'h3D;
    pkt[11] = 8'h7C;
    pkt[PACKET_BYTES-1] = 8'(255 - 8'h01 - 8'h3D - 8'h7C);
    send_packet(PACKET_BYTES, 1'b0);
  endtask

  task automatic test_random_traffic(input int n);
    int stop_at;
    int r;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        fill_good();
        send_packet(PACKET_BYTES, start_mark());
      end else if (r < 78) begin
        fill_good();
        spoil_packet();
        send_packet(PACKET_BYTES, start_mark());
      end else if (r < 90) begin
        fill_good();
        send_packet($urandom_range(1, PACKET_BYTES - 1), 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_requests++;
    repeat (8) begin
      fill_good();
      send_packet(PACKET_BYTES, start_mark());
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) pkt_store[i] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bad_sum();
    test_restart_mid_packet();
    test_packet_without_start();
    test_random_traffic(RANDOM_BYTES / 2);
    test_backpressure();
    test_random_traffic(RANDOM_BYTES / 2 - 8 * PACKET_BYTES);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_sensor_status_packet_decoder_top OK");
    end else begin
      $display("tb_sensor_status_packet_decoder_top NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sspd_pkg.sv
hdl/sspd_in_reg.sv
hdl/sspd_core.sv
hdl/sensor_status_packet_decoder_top.sv
bench/tb_sensor_status_packet_decoder_top.sv
